[rtl/amse_pkg.sv]
// Package for the MOV execute block: field widths, decode codes and the result record.
// No dependencies; taken in by the channel interfaces and the core.
package amse_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned RegW  = 4;

    localparam logic [3:0] OPC_MOV      = 4'd13;
    localparam logic [6:0] OPC_MOV_IMM  = 7'h1d;
    localparam logic [7:0] OPC_MOVW     = 8'h30;
    localparam logic [3:0] REG_PC       = 4'd15;
    localparam logic [4:0] SHIFT_MAX_M1 = 5'd31;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } t_shift;

    typedef struct packed {
        logic             accepted;
        logic [RegW-1:0]  dest_reg;
        logic [WordW-1:0] result_value;
        logic             flags_write;
        logic             negative_flag;
        logic             zero_flag;
        logic             carry_out;
        logic             pc_written;
    } t_mov_res;

endpackage

[rtl/amse_chan_if.sv]
// Valid/ready channel interfaces for the MOV execute block: instruction in, result out.
// Depends on amse_pkg for field widths.
interface amse_in_if
    import amse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WordW-1:0] instruction;
    logic [WordW-1:0] rm_value;
    logic             flag_c;

    modport source (output valid, output instruction, output rm_value, output flag_c,
                    input ready);
    modport sink   (input valid, input instruction, input rm_value, input flag_c,
                    output ready);
endinterface

interface amse_out_if
    import amse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [RegW-1:0]  dest_reg;
    logic [WordW-1:0] result_value;
    logic             flags_write;
    logic             negative_flag;
    logic             zero_flag;
    logic             carry_out;
    logic             pc_written;

    modport source (output valid, output accepted, output dest_reg, output result_value,
                    output flags_write, output negative_flag, output zero_flag,
                    output carry_out, output pc_written, input ready);
    modport sink   (input valid, input accepted, input dest_reg, input result_value,
                    input flags_write, input negative_flag, input zero_flag,
                    input carry_out, input pc_written, output ready);
endinterface

[rtl/arm_mov_shift_execute_core.sv]
// MOV execute core: decodes register-shift, modified-immediate and MOVW forms of MOV.
// Depends on amse_pkg and the channel interfaces in amse_chan_if.sv.
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------------------
//  i_instr   | in        | instruction, rm_value, flag_c
//  o_result  | out       | accepted, dest_reg, result_value, flags, pc_written
//
// One transaction per cycle sustained while the result channel is not stalled.
// Input register, one pass of decode and shifter logic, result register.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// A stalled result holds the pipe; the input register still refills as the result drains.
module arm_mov_shift_execute_core
    import amse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    amse_in_if.sink    i_instr,
    amse_out_if.source o_result
);

    logic             r_s1_valid;
    logic [WordW-1:0] r_instr;
    logic [WordW-1:0] r_rm;
    logic             r_cin;
    logic             r_out_valid;
    t_mov_res         r_out;
    t_mov_res         n_out;
    logic             s1_adv;

    assign s1_adv        = !r_out_valid || o_result.ready;
    assign i_instr.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_instr.ready) begin
            r_s1_valid <= i_instr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_instr.valid && i_instr.ready) begin
            r_instr <= i_instr.instruction;
            r_rm    <= i_instr.rm_value;
            r_cin   <= i_instr.flag_c;
        end
    end

    logic [RegW-1:0]  rd;
    logic             s_bit;
    logic [4:0]       imm5;
    t_shift           shty;
    logic [4:0]       amt_m1;
    logic             fill;
    logic [63:0]      right_ext;
    logic [32:0]      left_ext;
    logic [63:0]      ror_ext;
    logic [4:0]       rot;
    logic [63:0]      imm_ext;
    logic             is_reg;
    logic             is_imm;
    logic             is_movw;
    logic             ok;
    logic             s_eff;
    logic [WordW-1:0] res;
    logic             c;

    always_comb begin
        rd        = r_instr[15:12];
        s_bit     = r_instr[20];
        imm5      = r_instr[11:7];
        shty      = t_shift'(r_instr[6:5]);
        amt_m1    = (imm5 == 5'd0) ? SHIFT_MAX_M1 : (imm5 - 5'd1);
        fill      = (shty == SHIFT_ASR) ? r_rm[31] : 1'b0;
        right_ext = {{32{fill}}, r_rm} >> amt_m1;
        left_ext  = {1'b0, r_rm} << imm5;
        ror_ext   = {r_rm, r_rm} >> imm5;
        rot       = {r_instr[11:8], 1'b0};
        imm_ext   = {24'd0, r_instr[7:0], 24'd0, r_instr[7:0]} >> rot;

        is_reg  = (r_instr[27:25] == 3'd0) && (r_instr[24:21] == OPC_MOV)
                  && (r_instr[19:16] == 4'd0) && !r_instr[4];
        is_imm  = (r_instr[27:21] == OPC_MOV_IMM) && (r_instr[19:16] == 4'd0);
        is_movw = (r_instr[27:20] == OPC_MOVW);

        ok    = 1'b0;
        s_eff = s_bit;
        res   = '0;
        c     = r_cin;
        priority if (is_reg) begin
            ok = (r_instr[3:0] != REG_PC) && !((rd == REG_PC) && s_bit);
            unique case (shty)
                SHIFT_LSL: begin
                    res = left_ext[31:0];
                    c   = (imm5 == 5'd0) ? r_cin : left_ext[32];
                end
                SHIFT_LSR, SHIFT_ASR: begin
                    res = right_ext[32:1];
                    c   = right_ext[0];
                end
                SHIFT_ROR: begin
                    if (imm5 == 5'd0) begin
                        res = {r_cin, r_rm[31:1]};
                        c   = r_rm[0];
                    end else begin
                        res = ror_ext[31:0];
                        c   = ror_ext[31];
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
        end else if (is_imm) begin
            ok  = 1'b1;
            res = imm_ext[31:0];
            c   = (rot == 5'd0) ? r_cin : imm_ext[31];
        end else if (is_movw) begin
            ok    = (rd != REG_PC);
            s_eff = 1'b0;
            res   = {16'd0, r_instr[19:16], r_instr[11:0]};
        end else begin
            ok = 1'b0;
        end

        n_out = '0;
        if (ok) begin
            n_out.accepted     = 1'b1;
            n_out.dest_reg     = rd;
            n_out.result_value = res;
            n_out.pc_written   = (rd == REG_PC);
            if (s_eff) begin
                n_out.flags_write   = 1'b1;
                n_out.negative_flag = res[31];
                n_out.zero_flag     = (res == '0);
                n_out.carry_out     = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.accepted      = r_out.accepted;
    assign o_result.dest_reg      = r_out.dest_reg;
    assign o_result.result_value  = r_out.result_value;
    assign o_result.flags_write   = r_out.flags_write;
    assign o_result.negative_flag = r_out.negative_flag;
    assign o_result.zero_flag     = r_out.zero_flag;
    assign o_result.carry_out     = r_out.carry_out;
    assign o_result.pc_written    = r_out.pc_written;

`ifndef ASSERT_OFF
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.accepted |-> (r_out == '0))
        else $error("rejected transaction carries non-zero fields");

    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.flags_write
            |-> !r_out.negative_flag && !r_out.zero_flag && !r_out.carry_out)
        else $error("flags set without flag write");

    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.flags_write
            |-> (r_out.zero_flag == (r_out.result_value == '0))
                && (r_out.negative_flag == r_out.result_value[31]))
        else $error("N or Z flag disagrees with result");

    a_pc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.pc_written |-> r_out.accepted && (r_out.dest_reg == REG_PC))
        else $error("PC write without PC destination");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_instr.valid && i_instr.ready |=> r_s1_valid)
        else $error("accepted transaction lost from input register");
`endif

endmodule
